@@ hdl/two_button_debounce_press_classifier_assert.svh @@
// Assertion macros for the two-button debounce and press classifier.
// Uses the clk and rst signals of the module that includes it.
`ifndef TWO_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define TWO_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TBDPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TBDPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TBDPC_ASSERT_IMP(label, ante, cons, msg)
`define TBDPC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/tbdpc_pkg.sv @@
// Shared types and constants of the two-button debounce and press classifier.
// No dependencies.
package tbdpc_pkg;

  localparam int SAMPLE_COUNT = 4;
  localparam int PTR_W        = $clog2(SAMPLE_COUNT);
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int IDX_W        = 8;
  localparam int ACT_W        = 3;
  localparam int EV_W         = 2;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRESS_DELAY = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LONG_PRESS  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_LOCKOUT     = IDX_W'(3);

  localparam logic [CFG_W-1:0] RST_DEBOUNCE    = CFG_W'(50);
  localparam logic [CFG_W-1:0] RST_PRESS_DELAY = CFG_W'(100);
  localparam logic [CFG_W-1:0] RST_LONG_PRESS  = CFG_W'(1000);
  localparam logic [CFG_W-1:0] RST_LOCKOUT     = CFG_W'(300);

  localparam logic [EV_W-1:0] EV_NONE  = EV_W'(0);
  localparam logic [EV_W-1:0] EV_SHORT = EV_W'(1);
  localparam logic [EV_W-1:0] EV_LONG  = EV_W'(2);

  localparam logic [ACT_W-1:0] ACT_NONE    = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_A_SHORT = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_A_LONG  = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_B_SHORT = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_B_LONG  = ACT_W'(4);

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] press_delay_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] lockout_ms;
  } cfg_t;

endpackage

@@ hdl/tbdpc_cfg.sv @@
// Configuration register file: four 16-bit timing registers.
// Depends on tbdpc_pkg.
module tbdpc_cfg
  import tbdpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [IDX_W-1:0] index,
  input  logic [CFG_W-1:0] data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= RST_DEBOUNCE;
      cfg.press_delay_ms <= RST_PRESS_DELAY;
      cfg.long_press_ms  <= RST_LONG_PRESS;
      cfg.lockout_ms     <= RST_LOCKOUT;
    end else if (wr) begin
      case (index)
        REG_DEBOUNCE:    cfg.debounce_ms    <= data;
        REG_PRESS_DELAY: cfg.press_delay_ms <= data;
        REG_LONG_PRESS:  cfg.long_press_ms  <= data;
        REG_LOCKOUT:     cfg.lockout_ms     <= data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/tbdpc_button.sv @@
// Per-button debounce ring, debounce timer and press classifier.
// Computes a poll's event; state advances on update when unlocked. Depends on tbdpc_pkg.
module tbdpc_button
  import tbdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pin,
  input  logic              update,
  output logic [EV_W-1:0]   ev
);

  logic [SAMPLE_COUNT-1:0] hist, hist_next;
  logic [PTR_W-1:0]        wptr, wptr_next;
  logic                    prev, prev_next;
  logic                    settled, settled_next;
  logic [TIME_W-1:0]       change_at, change_at_next;
  logic [TIME_W-1:0]       press_at, press_at_next;
  logic [TIME_W-1:0]       event_at, event_at_next;
  logic                    long_seen, long_seen_next;
  logic                    handled, handled_next;

  logic              locked, stable, reading, settle, press_start, fire, is_long;
  logic [TIME_W-1:0] since_event, since_change, held;
  logic              mid_settled, mid_handled, mid_long;

  always_comb begin
    since_event  = now_ms - event_at;
    since_change = now_ms - change_at;
    locked       = since_event <= TIME_W'(cfg.lockout_ms);

    hist_next       = hist;
    hist_next[wptr] = pin;
    wptr_next       = (wptr == PTR_W'(SAMPLE_COUNT - 1)) ? '0 : wptr + PTR_W'(1);
    stable          = (&hist_next) || !(|hist_next);
    reading         = !hist_next[0];

    settle      = (reading == prev) && (since_change > TIME_W'(cfg.debounce_ms)) &&
                  (reading != settled);
    press_start = settle && !reading;
    held        = press_start ? '0 : now_ms - press_at;

    mid_settled = settle ? reading : settled;
    mid_handled = press_start ? 1'b0 : handled;
    mid_long    = press_start ? 1'b0 : long_seen;

    fire    = !mid_settled && !mid_handled && !mid_long &&
              (held > TIME_W'(cfg.press_delay_ms));
    is_long = held >= TIME_W'(cfg.long_press_ms);

    ev = EV_NONE;
    if (!locked && stable && fire) begin
      ev = is_long ? EV_LONG : EV_SHORT;
    end

    settled_next   = settled;
    change_at_next = change_at;
    press_at_next  = press_at;
    event_at_next  = event_at;
    long_seen_next = long_seen;
    handled_next   = handled;
    prev_next      = prev;
    if (stable) begin
      settled_next   = mid_settled;
      change_at_next = (reading != prev) ? now_ms : change_at;
      press_at_next  = press_start ? now_ms : press_at;
      if (fire) begin
        handled_next   = 1'b1;
        event_at_next  = now_ms;
        long_seen_next = is_long ? 1'b1 : mid_long;
      end else begin
        handled_next   = (mid_settled && mid_handled) ? 1'b0 : mid_handled;
        long_seen_next = (mid_settled && mid_handled) ? 1'b0 : mid_long;
        prev_next      = reading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist      <= '1;
      wptr      <= '0;
      prev      <= 1'b1;
      settled   <= 1'b1;
      change_at <= '0;
      press_at  <= '0;
      event_at  <= '0;
      long_seen <= 1'b0;
      handled   <= 1'b0;
    end else if (update && !locked) begin
      hist      <= hist_next;
      wptr      <= wptr_next;
      prev      <= prev_next;
      settled   <= settled_next;
      change_at <= change_at_next;
      press_at  <= press_at_next;
      event_at  <= event_at_next;
      long_seen <= long_seen_next;
      handled   <= handled_next;
    end
  end

endmodule

@@ hdl/two_button_debounce_press_classifier.sv @@
// An accepted poll passes the input register and then the result register, which holds its action.
// Throughput: one poll per cycle unless the output stalls; B skips its update when A has an event.
// Reset (rst, synchronous): timing registers return to 50/100/1000/300 ms, button state clears,
// both pipeline stages empty. No clearing pass; polls are taken from the first cycle after reset.
// Depends on tbdpc_pkg, tbdpc_cfg, tbdpc_button and the assertion macro header.
module two_button_debounce_press_classifier
  import tbdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pin_a,
  input  logic              pin_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ACT_W-1:0]  action,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic              s1_pin_a, s1_pin_b;
  logic              adv, upd_a, upd_b;
  logic [EV_W-1:0]   ev_a, ev_b;
  logic [ACT_W-1:0]  action_next;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !adv;
  assign upd_a     = s1_valid && adv;
  assign upd_b     = upd_a && (ev_a == EV_NONE);

  tbdpc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tbdpc_button u_btn_a (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .now_ms (s1_now),
    .pin    (s1_pin_a),
    .update (upd_a),
    .ev     (ev_a)
  );

  tbdpc_button u_btn_b (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .now_ms (s1_now),
    .pin    (s1_pin_b),
    .update (upd_b),
    .ev     (ev_b)
  );

  always_comb begin
    case (ev_a)
      EV_SHORT: action_next = ACT_A_SHORT;
      EV_LONG:  action_next = ACT_A_LONG;
      default: begin
        case (ev_b)
          EV_SHORT: action_next = ACT_B_SHORT;
          EV_LONG:  action_next = ACT_B_LONG;
          default:  action_next = ACT_NONE;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now   <= now_ms;
      s1_pin_a <= pin_a;
      s1_pin_b <= pin_b;
    end
    if (upd_a) begin
      action <= action_next;
    end
  end

`include "two_button_debounce_press_classifier_assert.svh"

  `TBDPC_ASSERT_IMP(a_stall_has_item, in_stall, s1_valid, "input stalled with empty stage")
  `TBDPC_ASSERT_IMP(a_action_range, out_valid, action <= ACT_B_LONG, "action code out of range")
  `TBDPC_ASSERT_IMP(a_b_skipped, upd_a && (ev_a != EV_NONE), !upd_b, "B updated after A event")
  `TBDPC_ASSERT_NEXT(a_result_follows, upd_a, out_valid, "processed item produced no result")

endmodule
